// ----- hw/rtl/smam_pkg.sv -----
package smam_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int INDEX_BITS = 8;
    localparam int VALUE_BITS = 32;

    localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int PTR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam int OP_BITS        = 2;
    localparam int STATUS_BITS    = 2;
    localparam int DIM_BITS       = 9;
    localparam int CFG_INDEX_BITS = 2;

    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_B = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_COMP
    } state_t;

    // Which list heads the shared unit consumes this step
    typedef struct packed {
        logic take_a;
        logic take_b;
    } merge_sel_t;

endpackage

// ----- hw/rtl/smam_in_if.sv -----
interface smam_in_if;
    import smam_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    op;
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, op, row, col, value, input ready);
    modport sink   (input valid, op, row, col, value, output ready);
endinterface

// ----- hw/rtl/smam_out_if.sv -----
interface smam_out_if;
    import smam_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [INDEX_BITS-1:0]  out_row;
    logic [INDEX_BITS-1:0]  out_col;
    logic [VALUE_BITS-1:0]  out_value;
    logic [STATUS_BITS-1:0] status;
    logic                   last;

    modport source (output valid, out_row, out_col, out_value, status, last, input ready);
    modport sink   (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

// ----- hw/rtl/smam_cfg_if.sv -----
interface smam_cfg_if;
    import smam_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DIM_BITS-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/smam_ram.sv -----
module smam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/smam_merge_unit.sv -----
module smam_merge_unit (
    input  smam_pkg::entry_t     head_a,
    input  smam_pkg::entry_t     head_b,
    input  logic                 has_a,
    input  logic                 has_b,
    output smam_pkg::merge_sel_t sel,
    output smam_pkg::entry_t     result
);
    import smam_pkg::*;

    logic [2*INDEX_BITS-1:0] key_a;
    logic [2*INDEX_BITS-1:0] key_b;
    logic                    a_first;
    logic                    b_first;

    assign key_a   = {head_a.row, head_a.col};
    assign key_b   = {head_b.row, head_b.col};
    assign a_first = key_a < key_b;
    assign b_first = key_b < key_a;

    always_comb
    begin
        sel    = '0;
        result = head_b;
        if (has_a && has_b)
        begin
            if (a_first)
            begin
                sel.take_a = 1'b1;
                result     = head_a;
            end
            else if (b_first)
            begin
                sel.take_b = 1'b1;
            end
            else
            begin
                // equal coordinates: add, wrapping
                sel.take_a   = 1'b1;
                sel.take_b   = 1'b1;
                result.value = head_a.value + head_b.value;
            end
        end
        else if (has_a)
        begin
            sel.take_a = 1'b1;
            result     = head_a;
        end
        else if (has_b)
        begin
            sel.take_b = 1'b1;
        end
    end
endmodule

// ----- hw/rtl/sparse_matrix_add_merge.sv -----
// Sparse matrix adder over two coordinate lists of up to LIST_DEPTH entries each,
// loaded in row-then-column order. A load request (op 0 or 1) appends to list A
// or B; loads into a full list are dropped. A run request (op 2) first checks the
// dimensions; a mismatch or two empty lists give one status result. Otherwise each
// merged result passes through the registered read of both list memories and then
// the shared compare/add unit, and waits there while the output is stalled. The
// input is not ready while a run is in progress. Both lists are empty after a run.
module sparse_matrix_add_merge (
    input  logic       clk,
    input  logic       rst_n,
    smam_in_if.sink    in,
    smam_out_if.source out,
    smam_cfg_if.sink   cfg
);
    import smam_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_BITS-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_BITS-1:0] cnt_b_reg, cnt_b_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [CNT_BITS-1:0] j_reg, j_next;

    logic [DIM_BITS-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]  out_row_reg, out_row_next;
    logic [INDEX_BITS-1:0]  out_col_reg, out_col_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   last_reg, last_next;

    logic       we_a, we_b;
    entry_t     load_entry;
    entry_t     head_a, head_b;
    logic       has_a, has_b;
    merge_sel_t sel;
    entry_t     merged;
    logic       out_free;
    logic       dim_mismatch;
    logic       no_entries;
    logic       done;

    assign load_entry.row   = in.row;
    assign load_entry.col   = in.col;
    assign load_entry.value = in.value;

    smam_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LIST_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[PTR_BITS-1:0]),
        .wdata (load_entry),
        .raddr (i_reg[PTR_BITS-1:0]),
        .rdata (head_a)
    );

    smam_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LIST_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[PTR_BITS-1:0]),
        .wdata (load_entry),
        .raddr (j_reg[PTR_BITS-1:0]),
        .rdata (head_b)
    );

    assign has_a = i_reg < cnt_a_reg;
    assign has_b = j_reg < cnt_b_reg;

    smam_merge_unit u_merge (
        .head_a (head_a),
        .head_b (head_b),
        .has_a  (has_a),
        .has_b  (has_b),
        .sel    (sel),
        .result (merged)
    );

    assign dim_mismatch = (rows_a_reg != rows_b_reg) || (cols_a_reg != cols_b_reg);
    assign no_entries   = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign out_free     = !out_valid_reg || out.ready;

    assign in.ready  = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign out.valid     = out_valid_reg;
    assign out.out_row   = out_row_reg;
    assign out.out_col   = out_col_reg;
    assign out.out_value = out_value_reg;
    assign out.status    = status_reg;
    assign out.last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_BITS'(1);
            cols_a_reg <= DIM_BITS'(1);
            rows_b_reg <= DIM_BITS'(1);
            cols_b_reg <= DIM_BITS'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROWS_A: rows_a_reg <= cfg.data;
                REG_COLS_A: cols_a_reg <= cfg.data;
                REG_ROWS_B: rows_b_reg <= cfg.data;
                REG_COLS_B: cols_b_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !out.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        we_a           = 1'b0;
        we_b           = 1'b0;
        done           = (i_reg + CNT_BITS'(sel.take_a) >= cnt_a_reg)
                      && (j_reg + CNT_BITS'(sel.take_b) >= cnt_b_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in.valid)
                begin
                    case (in.op)
                        OP_LOAD_A:
                        begin
                            // drop the request when the list is full
                            if (cnt_a_reg < CNT_BITS'(LIST_DEPTH))
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_BITS'(LIST_DEPTH))
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                        end
                        OP_RUN:  state_next = ST_START;
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                if (dim_mismatch || no_entries)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_value_next = '0;
                        status_next    = dim_mismatch ? STATUS_MISMATCH : STATUS_EMPTY;
                        last_next      = 1'b1;
                        cnt_a_next     = '0;
                        cnt_b_next     = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // wait for the registered read of both list heads
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = merged.row;
                    out_col_next   = merged.col;
                    out_value_next = merged.value;
                    status_next    = STATUS_VALID;
                    last_next      = done;
                    i_next         = i_reg + CNT_BITS'(sel.take_a);
                    j_next         = j_reg + CNT_BITS'(sel.take_b);
                    if (done)
                    begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready && in.op == OP_LOAD_A && cnt_a_reg < CNT_BITS'(LIST_DEPTH))
        |=> (cnt_a_reg == $past(cnt_a_reg) + 1'b1))
        else $error("list A count did not advance on an accepted load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (has_a || has_b))
        else $error("merge step with both lists exhausted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_COMP)
        |-> (i_reg <= cnt_a_reg && j_reg <= cnt_b_reg))
        else $error("merge pointer ran past its list");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smam_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_GAP      = 8;
    localparam int RANDOM_ITEMS  = 60;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int DRAIN_TAIL    = 20;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [INDEX_BITS-1:0]  row;
        logic [INDEX_BITS-1:0]  col;
        logic [VALUE_BITS-1:0]  value;
        status_t                status;
        logic                   last;
    } sum_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic clk;
    logic rst_n;

    smam_in_if  req_if ();
    smam_out_if sum_if ();
    smam_cfg_if cfg_if ();

    sparse_matrix_add_merge u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_if),
        .out   (sum_if),
        .cfg   (cfg_if)
    );

    // Shadow of the block's lists, fill counts and dimension registers
    entry_t               held_a [LIST_DEPTH];
    entry_t               held_b [LIST_DEPTH];
    int                   held_a_cnt;
    int                   held_b_cnt;
    logic [DIM_BITS-1:0]  dim_rows_a;
    logic [DIM_BITS-1:0]  dim_cols_a;
    logic [DIM_BITS-1:0]  dim_rows_b;
    logic [DIM_BITS-1:0]  dim_cols_b;

    sum_t expected_sums [$];

    int mismatch_count;
    int items_sent;
    int sums_checked;
    int runs_seen;
    int empty_runs;
    int mismatch_runs;
    int dropped_appends;
    int ignored_ops;
    int reg_writes;

    // Sender burst shaping
    bit gaps_on;
    int burst_left;

    // Long receiver hold-off, requested by bumping hold_seq
    int hold_seq;
    int hold_len;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_merge();
        int   i;
        int   j;
        sum_t s;
        logic [2*INDEX_BITS-1:0] key_a;
        logic [2*INDEX_BITS-1:0] key_b;

        i = 0;
        j = 0;
        runs_seen++;
        if (dim_rows_a != dim_rows_b || dim_cols_a != dim_cols_b)
        begin
            s = '{row: '0, col: '0, value: '0, status: STATUS_MISMATCH, last: 1'b1};
            expected_sums.push_back(s);
            mismatch_runs++;
        end
        else if (held_a_cnt == 0 && held_b_cnt == 0)
        begin
            s = '{row: '0, col: '0, value: '0, status: STATUS_EMPTY, last: 1'b1};
            expected_sums.push_back(s);
            empty_runs++;
        end
        else
        begin
            while (i < held_a_cnt || j < held_b_cnt)
            begin
                s.status = STATUS_VALID;
                if (i < held_a_cnt && j < held_b_cnt)
                begin
                    key_a = {held_a[i].row, held_a[i].col};
                    key_b = {held_b[j].row, held_b[j].col};
                    if (key_a < key_b)
                    begin
                        s.row = held_a[i].row;
                        s.col = held_a[i].col;
                        s.value = held_a[i].value;
                        i++;
                    end
                    else if (key_b < key_a)
                    begin
                        s.row = held_b[j].row;
                        s.col = held_b[j].col;
                        s.value = held_b[j].value;
                        j++;
                    end
                    else
                    begin
                        // same coordinate: add, wrapping at the value width
                        s.row = held_b[j].row;
                        s.col = held_b[j].col;
                        s.value = held_a[i].value + held_b[j].value;
                        i++;
                        j++;
                    end
                end
                else if (i < held_a_cnt)
                begin
                    s.row = held_a[i].row;
                    s.col = held_a[i].col;
                    s.value = held_a[i].value;
                    i++;
                end
                else
                begin
                    s.row = held_b[j].row;
                    s.col = held_b[j].col;
                    s.value = held_b[j].value;
                    j++;
                end
                s.last = (i >= held_a_cnt && j >= held_b_cnt);
                expected_sums.push_back(s);
            end
        end
        held_a_cnt = 0;
        held_b_cnt = 0;
    endfunction

    function automatic void predict_request(input logic [OP_BITS-1:0] op, input entry_t e);
        case (op)
            OP_LOAD_A:
            begin
                if (held_a_cnt < LIST_DEPTH)
                    held_a[held_a_cnt++] = e;
                else
                    dropped_appends++;
            end
            OP_LOAD_B:
            begin
                if (held_b_cnt < LIST_DEPTH)
                    held_b[held_b_cnt++] = e;
                else
                    dropped_appends++;
            end
            OP_RUN:
                predict_merge();
            default:
                ignored_ops++;
        endcase
    endfunction

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_request(input logic [OP_BITS-1:0] op, input entry_t e);
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        req_if.valid = 1'b1;
        req_if.op    = op;
        req_if.row   = e.row;
        req_if.col   = e.col;
        req_if.value = e.value;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_request(op, e);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_run();
        entry_t e;

        e.row   = INDEX_BITS'($urandom);
        e.col   = INDEX_BITS'($urandom);
        e.value = VALUE_BITS'($urandom);
        send_request(OP_RUN, e);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (expected_sums.size() > 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [DIM_BITS-1:0] data);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data  = data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (index)
            REG_ROWS_A: dim_rows_a = data;
            REG_COLS_A: dim_cols_a = data;
            REG_ROWS_B: dim_rows_b = data;
            default:    dim_cols_b = data;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_dims(input int ra, input int ca, input int rb, input int cb);
        wait_idle();
        write_reg(REG_ROWS_A, DIM_BITS'(ra));
        write_reg(REG_COLS_A, DIM_BITS'(ca));
        write_reg(REG_ROWS_B, DIM_BITS'(rb));
        write_reg(REG_COLS_B, DIM_BITS'(cb));
    endtask

    function automatic entry_t make_entry(input int row, input int col, input logic [31:0] value);
        entry_t e;

        e.row   = INDEX_BITS'(row);
        e.col   = INDEX_BITS'(col);
        e.value = VALUE_BITS'(value);
        return e;
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        int pick;

        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return VALUE_BITS'($urandom);
    endfunction

    function automatic int pick_dim();
        int pick;

        pick = $urandom_range(0, 3);
        if (pick == 0)
            return 1;
        else if (pick == 1)
            return 256;
        return $urandom_range(1, 256);
    endfunction

    function automatic int pick_size();
        return ($urandom_range(0, 7) == 0) ? LIST_DEPTH : $urandom_range(0, 5);
    endfunction

    // Build two sorted lists over one ascending key walk, then load them interleaved
    task automatic load_sorted_pair(input int size_a, input int size_b, input bit overlap);
        entry_t pa [$];
        entry_t pb [$];
        entry_t e;
        entry_t f;
        int key;
        int stride;
        int pick;
        bit want_a;
        bit want_b;

        key = $urandom_range(0, 255);
        stride = $urandom_range(0, 1) ? 3 : 1500;
        want_a = (size_a > 0);
        want_b = (size_b > 0);
        while (want_a || want_b)
        begin
            key += $urandom_range(1, stride);
            e.row = key[15:8];
            e.col = key[7:0];
            e.value = rand_value();
            pick = $urandom_range(0, overlap ? 2 : 1);
            if (pick == 2 && want_a && want_b)
            begin
                f = e;
                // now and then cancel to a zero sum
                f.value = ($urandom_range(0, 3) == 0) ? -e.value : rand_value();
                pa.push_back(e);
                pb.push_back(f);
            end
            else if ((pick == 0 && want_a) || !want_b)
                pa.push_back(e);
            else
                pb.push_back(e);
            want_a = (pa.size() < size_a);
            want_b = (pb.size() < size_b);
        end
        while (pa.size() + pb.size() > 0)
        begin
            if (pb.size() == 0 || (pa.size() > 0 && $urandom_range(0, 1)))
                send_request(OP_LOAD_A, pa.pop_front());
            else
                send_request(OP_LOAD_B, pb.pop_front());
        end
    endtask

    task automatic load_noise();
        int n;
        int pick;
        logic [OP_BITS-1:0] op;

        n = $urandom_range(0, 6);
        repeat (n)
        begin
            pick = $urandom_range(0, 4);
            op = (pick == 4) ? OP_UNUSED : ((pick < 2) ? OP_LOAD_A : OP_LOAD_B);
            send_request(op, make_entry($urandom_range(0, 255), $urandom_range(0, 255),
                                        rand_value()));
        end
    endtask

    task automatic test_empty_run();
        send_run();
    endtask

    task automatic test_dim_mismatch();
        set_dims(2, 1, 1, 1);
        send_request(OP_LOAD_A, make_entry(1, 1, 10));
        send_request(OP_LOAD_B, make_entry(1, 1, 20));
        send_run();
        // column mismatch alone; lists are already cleared
        set_dims(1, 1, 1, 256);
        send_run();
        set_dims(1, 256, 1, 256);
        send_run();
    endtask

    task automatic test_index_extremes();
        set_dims(256, 256, 256, 256);
        send_request(OP_LOAD_A, make_entry(0, 0, 32'hFFFF_FFFF));
        send_request(OP_LOAD_A, make_entry(0, 255, 32'h1234_5678));
        send_request(OP_LOAD_A, make_entry(255, 255, 32'h8000_0000));
        send_request(OP_LOAD_B, make_entry(0, 0, 32'h0000_0001));
        send_request(OP_LOAD_B, make_entry(255, 0, 32'h0000_0000));
        send_request(OP_LOAD_B, make_entry(255, 255, 32'h8000_0000));
        send_request(OP_UNUSED, make_entry(255, 255, 32'hFFFF_FFFF));
        send_run();
    endtask

    task automatic test_unsorted_lists();
        set_dims(1, 1, 1, 1);
        send_request(OP_LOAD_A, make_entry(9, 9, 7));
        send_request(OP_LOAD_A, make_entry(3, 3, 8));
        send_request(OP_LOAD_B, make_entry(4, 4, 9));
        send_request(OP_LOAD_B, make_entry(0, 200, 1));
        send_run();
    endtask

    task automatic test_random_merges();
        int goal;
        int rows;
        int cols;
        int dims [4];
        int which;
        int kind;
        int sa;
        int sb;

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            rows = pick_dim();
            cols = pick_dim();
            dims = '{rows, cols, rows, cols};
            if ($urandom_range(0, 4) == 0)
            begin
                which = $urandom_range(0, 3);
                dims[which] = (dims[which] % 256) + 1;
            end
            set_dims(dims[0], dims[1], dims[2], dims[3]);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    sa = pick_size();
                    sb = pick_size();
                    load_sorted_pair(sa, sb, 1'b1);
                    if (sa == LIST_DEPTH)
                        send_request(OP_LOAD_A, make_entry(0, 0, rand_value()));
                end
                else if (kind < 9)
                    load_noise();
                send_run();
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_dims(256, 256, 256, 256);
        gaps_on = 1'b0;
        hold_len = HOLD_CYCLES;
        hold_seq++;
        load_sorted_pair(LIST_DEPTH, LIST_DEPTH, 1'b0);
        send_request(OP_LOAD_A, make_entry(255, 255, rand_value()));
        send_request(OP_LOAD_B, make_entry(255, 255, rand_value()));
        send_run();
        // keep offering while the merge output is held off
        load_sorted_pair(3, 4, 1'b1);
        send_run();
        gaps_on = 1'b1;
    endtask

    task automatic finish_run();
        int waited;

        wait_idle();
        waited = 0;
        while (expected_sums.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
        if (expected_sums.size() > 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_sums.size());
        end
        $display("Run covered %0d requests: %0d merges, %0d empty, %0d dimension mismatch,",
                 items_sent, runs_seen, empty_runs, mismatch_runs);
        $display("%0d dropped appends, %0d ignored ops, %0d register writes, %0d results checked",
                 dropped_appends, ignored_ops, reg_writes, sums_checked);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    endtask

    initial
    begin : main
        req_if.valid = 1'b0;
        req_if.op    = OP_LOAD_A;
        req_if.row   = '0;
        req_if.col   = '0;
        req_if.value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ROWS_A;
        cfg_if.data  = '0;
        dim_rows_a = DIM_BITS'(1);
        dim_cols_a = DIM_BITS'(1);
        dim_rows_b = DIM_BITS'(1);
        dim_cols_b = DIM_BITS'(1);
        held_a_cnt = 0;
        held_b_cnt = 0;
        mismatch_count = 0;
        items_sent = 0;
        sums_checked = 0;
        runs_seen = 0;
        empty_runs = 0;
        mismatch_runs = 0;
        dropped_appends = 0;
        ignored_ops = 0;
        reg_writes = 0;
        gaps_on = 1'b1;
        burst_left = 0;
        hold_seq = 0;
        hold_len = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_run();
        test_dim_mismatch();
        test_index_extremes();
        test_unsorted_lists();
        test_random_merges();
        test_output_backpressure();
        finish_run();
    end

    initial
    begin : receiver
        rx_mode_t mode;
        int mode_left;
        int hold_left;
        int seen_seq;

        sum_if.ready = 1'b0;
        mode = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        seen_seq = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = hold_len;
            end
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                sum_if.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:   sum_if.ready = 1'b1;
                    RX_COIN:     sum_if.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: sum_if.ready = (mode_left % 3) != 0;
                    default:     sum_if.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_sums
        sum_t got;
        sum_t want;

        if (rst_n && sum_if.valid && sum_if.ready)
        begin
            got.row    = sum_if.out_row;
            got.col    = sum_if.out_col;
            got.value  = sum_if.out_value;
            got.status = status_t'(sum_if.status);
            got.last   = sum_if.last;
            if (expected_sums.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result (%0d,%0d) %h status %0d last %0b",
                             $time, got.row, got.col, got.value, got.status, got.last);
            end
            else
            begin
                want = expected_sums.pop_front();
                sums_checked++;
                if (got.row !== want.row || got.col !== want.col || got.value !== want.value
                    || got.status !== want.status || got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: expected (%0d,%0d) %h status %0d last %0b,",
                                  " got (%0d,%0d) %h status %0d last %0b"},
                                 $time, want.row, want.col, want.value, want.status,
                                 want.last, got.row, got.col, got.value, got.status,
                                 got.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sparse_matrix_add_merge.f -----
hw/rtl/smam_pkg.sv
hw/rtl/smam_in_if.sv
hw/rtl/smam_out_if.sv
hw/rtl/smam_cfg_if.sv
hw/rtl/smam_ram.sv
hw/rtl/smam_merge_unit.sv
hw/rtl/sparse_matrix_add_merge.sv
tb/tb_top.sv
